### hdl/audio_to_direct_recording_bits_macros.svh
// Assertion macros for the direct recording bit encoder
`ifndef AUDIO_TO_DIRECT_RECORDING_BITS_MACROS_SVH
`define AUDIO_TO_DIRECT_RECORDING_BITS_MACROS_SVH

`ifndef SYNTH
`define ATDRB_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ATDRB_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ATDRB_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define ATDRB_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

### hdl/atdrb_pkg.sv
// Shared types and constants of the direct recording bit encoder
package atdrb_pkg;

  localparam int unsigned CNT_W   = 9;
  localparam int unsigned TOTAL_W = 24;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [TOTAL_W-1:0] total_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MODE      = 2'd1,
    REG_PERIOD    = 2'd2,
    REG_TSB       = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic level;
    logic last;
    logic clipped;
    cnt_t count;
  } pack_cmd_t;

endpackage

### hdl/audio_to_direct_recording_bits.sv
// Direct mode: each sample passes to the packer, waiting while the output beat is stalled.
// Resample mode: a sample that extends the open run is taken in idle; a run
// end passes through the multiply, the bit-serial divider and the packer,
// which waits while the output beat is stalled.
// rst_ni clears stream state, the output beat and the registers to defaults.
`include "audio_to_direct_recording_bits_macros.svh"

module audio_to_direct_recording_bits #(
  parameter int unsigned MAX_RUN_BITS = 504,
  parameter int unsigned RUN_WIDTH    = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  sample_value_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  packed_byte_o,
  output logic [3:0]  valid_bits_o,
  output logic        final_byte_o,
  output logic [23:0] total_bytes_o,
  output logic        run_clipped_o
);

  localparam int unsigned NUM_W = RUN_WIDTH + 25;
  localparam int unsigned DIV_W = NUM_W - 8;
  localparam logic [RUN_WIDTH-1:0] RUN_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_PACK = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [7:0]           threshold_q;
  logic                 mode_q;
  logic [23:0]          period_q;
  logic [15:0]          tsb_q;
  logic [15:0]          tsb_eff;

  logic                 started_q, started_d;
  logic                 run_level_q, run_level_d;
  logic [RUN_WIDTH-1:0] run_len_q, run_len_d;
  logic [RUN_WIDTH-1:0] emit_len_q, emit_len_d;
  logic                 emit_level_q, emit_level_d;
  logic                 last_q, last_d;
  logic [NUM_W-1:0]     prod_q;
  logic [NUM_W-1:0]     product;
  logic                 div_start_q;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;
  logic                 clip;
  atdrb_pkg::cnt_t      bits;
  logic                 level;
  logic                 cfg_wr;
  logic                 cmd_valid;
  atdrb_pkg::pack_cmd_t cmd;
  logic                 pk_busy;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign tsb_eff = (tsb_q == 16'd0) ? 16'd1 : tsb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= 8'd127;
      mode_q      <= 1'b0;
      period_q    <= 24'd20317;
      tsb_q       <= 16'd79;
    end else if (cfg_wr) begin
      case (atdrb_pkg::reg_idx_e'(paddr[3:2]))
        atdrb_pkg::REG_THRESHOLD: threshold_q <= pwdata[7:0];
        atdrb_pkg::REG_MODE:      mode_q      <= pwdata[0];
        atdrb_pkg::REG_PERIOD:    period_q    <= pwdata[23:0];
        atdrb_pkg::REG_TSB:       tsb_q       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (atdrb_pkg::reg_idx_e'(paddr[3:2]))
      atdrb_pkg::REG_THRESHOLD: prdata = {24'd0, threshold_q};
      atdrb_pkg::REG_MODE:      prdata = {31'd0, mode_q};
      atdrb_pkg::REG_PERIOD:    prdata = {8'd0, period_q};
      atdrb_pkg::REG_TSB:       prdata = {16'd0, tsb_q};
      default:                  prdata = '0;
    endcase
  end

  assign in_ready_o = state_q == S_IDLE;
  assign level      = sample_value_i > threshold_q;
  assign product    = NUM_W'(emit_len_q) * NUM_W'(period_q) + NUM_W'({tsb_eff, 7'd0});

  always_comb begin
    clip = div_quo > DIV_W'(MAX_RUN_BITS);
    if (div_quo == '0) begin
      bits = atdrb_pkg::cnt_t'(1);
    end else if (clip) begin
      bits = atdrb_pkg::cnt_t'(MAX_RUN_BITS);
    end else begin
      bits = div_quo[atdrb_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    logic emit;
    emit         = 1'b0;
    state_d      = state_q;
    started_d    = started_q;
    run_level_d  = run_level_q;
    run_len_d    = run_len_q;
    emit_len_d   = emit_len_q;
    emit_level_d = emit_level_q;
    last_d       = last_q;
    cmd_valid    = 1'b0;
    cmd          = '{level: emit_level_q, last: last_q, clipped: clip, count: bits};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = is_last_i;
          if (!mode_q) begin
            cmd_valid = 1'b1;
            cmd       = '{level: level, last: is_last_i, clipped: 1'b0,
                          count: atdrb_pkg::cnt_t'(1)};
            state_d   = S_PACK;
            if (is_last_i) begin
              started_d   = 1'b0;
              run_level_d = 1'b0;
              run_len_d   = '0;
            end
          end else begin
            if (!started_q) begin
              started_d   = 1'b1;
              run_level_d = level;
              run_len_d   = RUN_WIDTH'(1);
            end else if (level == run_level_q) begin
              if (run_len_q != RUN_MAX) begin
                run_len_d = run_len_q + RUN_WIDTH'(1);
              end
            end else if (!is_last_i) begin
              emit         = 1'b1;
              emit_len_d   = run_len_q;
              emit_level_d = run_level_q;
              run_level_d  = level;
              run_len_d    = RUN_WIDTH'(1);
            end
            if (is_last_i) begin
              emit         = 1'b1;
              emit_len_d   = run_len_d;
              emit_level_d = run_level_d;
              started_d    = 1'b0;
              run_level_d  = 1'b0;
              run_len_d    = '0;
            end
            if (emit) begin
              state_d = S_MUL;
            end
          end
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          cmd_valid = 1'b1;
          state_d   = S_PACK;
        end
      end
      S_PACK: begin
        if (!pk_busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      run_level_q <= 1'b0;
      run_len_q   <= '0;
      div_start_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      run_level_q <= run_level_d;
      run_len_q   <= run_len_d;
      div_start_q <= state_q == S_MUL;
    end
  end

  always_ff @(posedge clk_i) begin
    emit_len_q   <= emit_len_d;
    emit_level_q <= emit_level_d;
    last_q       <= last_d;
    if (state_q == S_MUL) begin
      prod_q <= product;
    end
  end

  atdrb_div #(
    .DW(DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (prod_q[NUM_W-1:8]),
    .divisor_i  (tsb_eff),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  atdrb_packer u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .busy_o        (pk_busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_byte_o (packed_byte_o),
    .valid_bits_o  (valid_bits_o),
    .final_byte_o  (final_byte_o),
    .total_bytes_o (total_bytes_o),
    .run_clipped_o (run_clipped_o)
  );

  `ATDRB_ASSERT_IMP(a_idle_packer_quiet, clk_i, rst_ni, in_ready_o, !pk_busy)
  `ATDRB_ASSERT_IMP(a_full_unless_final, clk_i, rst_ni, out_valid_o && !final_byte_o, valid_bits_o == 4'd8)
  `ATDRB_ASSERT_IMP(a_div_done_in_div, clk_i, rst_ni, div_done, state_q == S_DIV)
  `ATDRB_ASSERT_NXT(a_cmd_makes_busy, clk_i, rst_ni, cmd_valid, pk_busy)

endmodule

### hdl/atdrb_div.sv
// Iterative restoring divider, one quotient bit per cycle
module atdrb_div #(
  parameter int unsigned DW = 41
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [15:0]   divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [15:0]   rem_q;
  logic [15:0]   div_q;
  logic [DW-1:0] quo_q;

  logic [16:0]   rem_sh;
  logic          ge;
  logic [15:0]   rem_nx;
  logic [DW-1:0] quo_nx;
  logic          last_step;

  always_comb begin
    rem_sh    = {rem_q, quo_q[DW-1]};
    ge        = rem_sh >= {1'b0, div_q};
    rem_nx    = ge ? 16'(rem_sh - {1'b0, div_q}) : rem_sh[15:0];
    quo_nx    = {quo_q[DW-2:0], ge};
    last_step = cnt_q == CW'(DW - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (last_step) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_nx;
      rem_q <= rem_nx;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### hdl/atdrb_packer.sv
// Bit packer: fills bytes MSB first, flushes the tail, holds the output beat
module atdrb_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  atdrb_pkg::pack_cmd_t cmd_i,
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          packed_byte_o,
  output logic [3:0]          valid_bits_o,
  output logic                final_byte_o,
  output logic [23:0]         total_bytes_o,
  output logic                run_clipped_o
);

  logic              busy_q, busy_d;
  atdrb_pkg::cnt_t   left_q, left_d;
  logic              level_q, level_d;
  logic              last_q, last_d;
  logic              clip_q, clip_d;
  logic [7:0]        acc_q, acc_d;
  logic [2:0]        held_q, held_d;
  atdrb_pkg::total_t count_q, count_d;
  logic              out_valid_q;
  logic [7:0]        byte_q;
  logic [3:0]        vbits_q;
  logic              final_q;
  atdrb_pkg::total_t total_q;
  logic              oclip_q;

  logic [3:0]        room;
  logic [3:0]        n;
  logic [3:0]        sum;
  logic              full;
  logic [15:0]       tmp16;
  logic [15:0]       ones16;
  logic [7:0]        acc_new;
  logic              out_free;
  logic              emit;
  logic [7:0]        e_byte;
  logic [3:0]        e_valid;
  logic              e_final;
  atdrb_pkg::total_t e_total;

  always_comb begin
    room     = 4'd8 - {1'b0, held_q};
    n        = (left_q < atdrb_pkg::cnt_t'(room)) ? left_q[3:0] : room;
    sum      = {1'b0, held_q} + n;
    full     = sum == 4'd8;
    tmp16    = {8'h00, acc_q} << n;
    ones16   = (16'd1 << n) - 16'd1;
    acc_new  = tmp16[7:0] | (level_q ? ones16[7:0] : 8'h00);
    out_free = !out_valid_q || out_ready_i;
    e_total  = count_q + atdrb_pkg::total_t'(1);
  end

  always_comb begin
    busy_d  = busy_q;
    left_d  = left_q;
    level_d = level_q;
    last_d  = last_q;
    clip_d  = clip_q;
    acc_d   = acc_q;
    held_d  = held_q;
    count_d = count_q;
    emit    = 1'b0;
    e_byte  = acc_new;
    e_valid = 4'd8;
    e_final = 1'b0;
    if (cmd_valid_i) begin
      busy_d  = 1'b1;
      left_d  = cmd_i.count;
      level_d = cmd_i.level;
      last_d  = cmd_i.last;
      clip_d  = cmd_i.clipped;
    end else if (busy_q) begin
      if (left_q != '0) begin
        if (!full) begin
          acc_d  = acc_new;
          held_d = sum[2:0];
          left_d = left_q - atdrb_pkg::cnt_t'(n);
        end else if (out_free) begin
          emit    = 1'b1;
          e_final = last_q && (left_q == atdrb_pkg::cnt_t'(n));
          acc_d   = '0;
          held_d  = '0;
          left_d  = left_q - atdrb_pkg::cnt_t'(n);
          count_d = e_total;
        end
      end else if (!last_q) begin
        busy_d = 1'b0;
      end else if (held_q == '0) begin
        busy_d  = 1'b0;
        count_d = '0;
      end else if (out_free) begin
        emit    = 1'b1;
        e_byte  = acc_q << (4'd8 - {1'b0, held_q});
        e_valid = {1'b0, held_q};
        e_final = 1'b1;
        busy_d  = 1'b0;
        acc_d   = '0;
        held_d  = '0;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      left_q      <= '0;
      acc_q       <= '0;
      held_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      held_q  <= held_d;
      count_q <= count_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    last_q  <= last_d;
    clip_q  <= clip_d;
    if (emit) begin
      byte_q  <= e_byte;
      vbits_q <= e_valid;
      final_q <= e_final;
      total_q <= e_total;
      oclip_q <= clip_q;
    end
  end

  assign busy_o        = busy_q;
  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = byte_q;
  assign valid_bits_o  = vbits_q;
  assign final_byte_o  = final_q;
  assign total_bytes_o = total_q;
  assign run_clipped_o = oclip_q;

endmodule

### tb/sv/audio_to_direct_recording_bits_test.sv
// Self-checking testbench of the direct recording bit encoder, random stalls on both sides
`timescale 1ns / 1ps

module audio_to_direct_recording_bits_test;

  localparam int unsigned RUN_BIT_CAP   = 504;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned RANDOM_ITEMS  = 120;

  typedef struct packed {
    logic [7:0]        pbyte;
    logic [3:0]        nbits;
    logic              last_beat;
    atdrb_pkg::total_t total;
    logic              clipped;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  sample_value_i = '0;
  logic        is_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  packed_byte_o;
  logic [3:0]  valid_bits_o;
  logic        final_byte_o;
  logic [23:0] total_bytes_o;
  logic        run_clipped_o;

  // register shadows
  logic [7:0]  thr_cfg = 8'd127;
  logic        resample_cfg = 1'b0;
  logic [23:0] period_cfg = 24'd20317;
  logic [15:0] bitlen_cfg = 16'd79;

  // stream state of the predictor
  logic        run_open = 1'b0;
  logic        run_lvl = 1'b0;
  logic [23:0] run_len = '0;
  logic [7:0]  acc = '0;
  int unsigned held = 0;
  logic [23:0] byte_cnt = '0;

  beat_t step_beats[$];
  beat_t pending_beats[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  bit steady = 1'b0;

  audio_to_direct_recording_bits dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .sample_value_i, .is_last_i,
    .out_valid_o, .out_ready_i, .packed_byte_o, .valid_bits_o, .final_byte_o,
    .total_bytes_o, .run_clipped_o
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) out_ready_i <= steady || ($urandom_range(99) >= 34);

  always @(posedge clk_i) begin : beat_check
    beat_t want;
    beat_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{pbyte: packed_byte_o, nbits: valid_bits_o, last_beat: final_byte_o,
              total: total_bytes_o, clipped: run_clipped_o};
      if (pending_beats.size() == 0) begin
        if (errors < 10)
          $display("mismatch: unexpected beat byte %02h bits %0d",
                   got.pbyte, got.nbits, " last %0b total %0d clip %0b",
                   got.last_beat, got.total, got.clipped);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          if (errors < 10)
            $display("mismatch: exp byte %02h bits %0d last %0b total %0d clip %0b",
                     want.pbyte, want.nbits, want.last_beat, want.total, want.clipped,
                     " / got byte %02h bits %0d last %0b total %0d clip %0b",
                     got.pbyte, got.nbits, got.last_beat, got.total, got.clipped);
          errors++;
        end
      end
    end
  end

  function automatic void put_beat(input logic [7:0] b, input logic [3:0] n);
    byte_cnt = byte_cnt + 1'b1;
    step_beats.push_back('{pbyte: b, nbits: n, last_beat: 1'b0, total: byte_cnt,
                           clipped: 1'b0});
  endfunction

  function automatic void shift_bit(input logic b);
    acc = {acc[6:0], b};
    held++;
    if (held == 8) begin
      put_beat(acc, 4'd8);
      acc = '0;
      held = 0;
    end
  endfunction

  function automatic bit close_run();
    longint unsigned tsb;
    longint unsigned num;
    longint unsigned nbits;
    bit clip;
    tsb = (bitlen_cfg == 0) ? 1 : bitlen_cfg;
    num = run_len * period_cfg + tsb * 128;
    nbits = num / (tsb * 256);
    clip = 1'b0;
    if (nbits == 0) nbits = 1;
    if (nbits > RUN_BIT_CAP) begin
      nbits = RUN_BIT_CAP;
      clip = 1'b1;
    end
    for (longint unsigned i = 0; i < nbits; i++) shift_bit(run_lvl);
    return clip;
  endfunction

  function automatic void encode_sample(input logic [7:0] s, input logic l);
    logic lvl;
    bit clip;
    lvl = (s > thr_cfg);
    clip = 1'b0;
    step_beats.delete();
    if (resample_cfg) begin
      if (!run_open) begin
        run_open = 1'b1;
        run_lvl = lvl;
        run_len = 24'd1;
      end else if (lvl == run_lvl) begin
        if (run_len != '1) run_len = run_len + 1'b1;
      end else if (!l) begin
        clip = close_run();
        run_lvl = lvl;
        run_len = 24'd1;
      end
      if (l) clip = close_run();
    end else begin
      shift_bit(lvl);
    end
    if (l) begin
      if (held != 0) put_beat(acc << (8 - held), 4'(held));
      if (step_beats.size() > 0) step_beats[step_beats.size()-1].last_beat = 1'b1;
      run_open = 1'b0;
      run_lvl = 1'b0;
      run_len = '0;
      acc = '0;
      held = 0;
      byte_cnt = '0;
    end
    foreach (step_beats[k]) begin
      if (clip) step_beats[k].clipped = 1'b1;
      pending_beats.push_back(step_beats[k]);
    end
  endfunction

  function automatic logic [7:0] level_sample(input logic high);
    if (high && thr_cfg != 8'hFF) return 8'($urandom_range(255, int'(thr_cfg) + 1));
    if (!high) return 8'($urandom_range(int'(thr_cfg), 0));
    return 8'($urandom_range(255));
  endfunction

  task automatic write_reg(input atdrb_pkg::reg_idx_e idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      atdrb_pkg::REG_THRESHOLD: thr_cfg = value[7:0];
      atdrb_pkg::REG_MODE:      resample_cfg = value[0];
      atdrb_pkg::REG_PERIOD:    period_cfg = value[23:0];
      atdrb_pkg::REG_TSB:       bitlen_cfg = value[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [7:0] s, input logic l);
    in_valid_i <= 1'b1;
    sample_value_i <= s;
    is_last_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
    encode_sample(s, l);
    items_sent++;
    if (!steady && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 34);
    end
  endtask

  // drop valid, drain expected beats, then let any silent run end finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_direct_bits();
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd127, 1'b0);
    send_sample(8'd128, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd200, 1'b1);
    settle();
  endtask

  task automatic test_threshold_limits();
    write_reg(atdrb_pkg::REG_THRESHOLD, 32'd255);
    send_sample(8'd255, 1'b1);
    settle();
    write_reg(atdrb_pkg::REG_THRESHOLD, 32'd0);
    send_sample(8'd1, 1'b1);
    settle();
    write_reg(atdrb_pkg::REG_THRESHOLD, 32'd127);
  endtask

  task automatic test_run_resampling();
    write_reg(atdrb_pkg::REG_MODE, 32'd1);
    send_sample(8'd200, 1'b0);
    send_sample(8'd200, 1'b0);
    send_sample(8'd200, 1'b0);
    send_sample(8'd10, 1'b0);
    send_sample(8'd10, 1'b0);
    send_sample(8'd250, 1'b1);
    settle();
    send_sample(8'd90, 1'b1);
    settle();
    send_sample(8'd5, 1'b0);
    send_sample(8'd5, 1'b1);
    settle();
  endtask

  task automatic test_run_clipping();
    write_reg(atdrb_pkg::REG_PERIOD, 32'hFF_FFFF);
    write_reg(atdrb_pkg::REG_TSB, 32'd0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b1);
    settle();
    write_reg(atdrb_pkg::REG_PERIOD, 32'd0);
    write_reg(atdrb_pkg::REG_TSB, 32'hFFFF);
    send_sample(8'd77, 1'b1);
    settle();
  endtask

  task automatic test_mode_change();
    write_reg(atdrb_pkg::REG_PERIOD, 32'd20317);
    write_reg(atdrb_pkg::REG_TSB, 32'd79);
    send_sample(8'd200, 1'b0);
    send_sample(8'd200, 1'b0);
    settle();
    write_reg(atdrb_pkg::REG_MODE, 32'd0);
    send_sample(8'd10, 1'b0);
    send_sample(8'd10, 1'b0);
    settle();
    write_reg(atdrb_pkg::REG_MODE, 32'd1);
    send_sample(8'd200, 1'b1);
    settle();
  endtask

  task automatic test_random_streams();
    int unsigned first;
    int phase;
    int runs;
    int len;
    logic lvl;
    bit noisy;
    bit closed;
    first = items_sent;
    phase = 0;
    while (items_sent < first + RANDOM_ITEMS) begin
      steady = (phase >= 1 && phase < 3);
      if ($urandom_range(1)) begin
        case ($urandom_range(3))
          0: write_reg(atdrb_pkg::REG_THRESHOLD, 32'd0);
          1: write_reg(atdrb_pkg::REG_THRESHOLD, 32'd255);
          default: write_reg(atdrb_pkg::REG_THRESHOLD, $urandom_range(255));
        endcase
      end
      if ($urandom_range(1)) write_reg(atdrb_pkg::REG_MODE, $urandom_range(1));
      if ($urandom_range(1)) begin
        case ($urandom_range(7))
          0: write_reg(atdrb_pkg::REG_PERIOD, 32'd0);
          1: write_reg(atdrb_pkg::REG_PERIOD, 32'd1);
          2, 3: write_reg(atdrb_pkg::REG_PERIOD, 32'd20317);
          4, 5: write_reg(atdrb_pkg::REG_PERIOD, $urandom_range(200000, 1));
          6: write_reg(atdrb_pkg::REG_PERIOD, 32'hFF_FFFF);
          default: write_reg(atdrb_pkg::REG_PERIOD, $urandom & 32'hFF_FFFF);
        endcase
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(7))
          0: write_reg(atdrb_pkg::REG_TSB, 32'd0);
          1: write_reg(atdrb_pkg::REG_TSB, 32'd1);
          2, 3: write_reg(atdrb_pkg::REG_TSB, 32'd79);
          4: write_reg(atdrb_pkg::REG_TSB, 32'hFFFF);
          default: write_reg(atdrb_pkg::REG_TSB, $urandom_range(400, 1));
        endcase
      end
      noisy = ($urandom_range(99) < 20);
      closed = ($urandom_range(99) < 85);
      runs = $urandom_range(6, 1);
      for (int r = 0; r < runs; r++) begin
        lvl = 1'($urandom_range(1));
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
        for (int k = 0; k < len; k++) begin
          if (noisy)
            send_sample(8'($urandom_range(255)), $urandom_range(15) == 0);
          else
            send_sample(level_sample(lvl), closed && r == runs - 1 && k == len - 1);
        end
      end
      settle();
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_direct_bits();
    test_threshold_limits();
    test_run_resampling();
    test_run_clipping();
    test_mode_change();
    test_random_streams();
    settle();
    if (pending_beats.size() != 0) begin
      if (errors < 10) $display("mismatch: %0d expected beats never came", pending_beats.size());
      errors++;
    end
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
